FILE: hdl/hfd_pkg.sv
package hfd_pkg;

  // Number of lines the block can serve at most, and the default.
  localparam int MAX_LINES = 8;
  localparam int DEF_LINES = 8;

  // Reset value of the flash window register.
  localparam logic [7:0] FLASH_WINDOW_RESET = 8'd10;

  // Input commands.
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_ENGAGE  = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  // Event kinds.
  localparam logic [1:0] KIND_OFFHOOK = 2'd0;
  localparam logic [1:0] KIND_FLASH   = 2'd1;
  localparam logic [1:0] KIND_ONHOOK  = 2'd2;

  // What the line unit is told about the line under scan.
  typedef struct packed {
    logic       is_tick;    // tick pass, else hook sample pass
    logic       changed;    // unmasked hook change on this line
    logic       level;      // new hook level, high is on-hook
    logic       pending;    // delayed relay release waits on this line
    logic [7:0] timer;      // current timer value
    logic [7:0] window;     // flash window register
  } line_req_t;

  // What the line unit decides for that line.
  typedef struct packed {
    logic [7:0] timer_next;
    logic       emit;
    logic [1:0] kind;
    logic       relay_off;  // clear relay and pending bits
  } line_res_t;

endpackage

FILE: hdl/hfd_line_unit.sv
module hfd_line_unit
  import hfd_pkg::*;
(
  input  line_req_t req,
  output line_res_t res
);

  logic       timer_run;
  logic [7:0] timer_dec;
  logic [7:0] window_eff;

  assign timer_run  = (req.timer != 8'd0);
  assign timer_dec  = req.timer - 8'd1;
  // A zero window acts as one tick.
  assign window_eff = (req.window == 8'd0) ? 8'd1 : req.window;

  always_comb begin
    res.timer_next = req.timer;
    res.emit       = 1'b0;
    res.kind       = KIND_OFFHOOK;
    res.relay_off  = 1'b0;
    if (req.is_tick) begin
      if (timer_run) begin
        res.timer_next = timer_dec;
        if (timer_dec == 8'd0) begin
          if (req.pending) begin
            res.relay_off = 1'b1;
          end else begin
            res.emit = 1'b1;
            res.kind = KIND_ONHOOK;
          end
        end
      end
    end else if (req.changed) begin
      if (!req.level) begin
        res.emit = 1'b1;
        if (timer_run) begin
          res.timer_next = 8'd0;
          res.kind       = KIND_FLASH;
        end
      end else if (!timer_run) begin
        res.timer_next = window_eff;
      end
    end
  end

endmodule

FILE: hdl/hook_flash_discriminator.sv
// Hook flash discriminator. Items enter on the s_axis channel: tuser carries
// the command (hook sample, timer tick, engage relay, delayed relay release)
// and tdata the hook bits, the addressed line and the release tick count.
// Events leave on the m_axis channel, one item per event, in ascending line
// order: tdata carries the line, tuser the kind (off-hook, flash, on-hook) and
// tlast marks the last event caused by one input item. The flash window
// register is written over the cfg channel, which is always ready.
//
// Relay commands and hook samples without an unmasked change are handled
// in idle. A tick, or a sample that changes any unmasked line, starts a scan
// that visits one line per cycle, unless the receiver stalls, through a
// single shared line unit; such an item holds the input channel until the
// scan is done and the block is back in idle. The event of line i is
// registered when the scan reaches that line. Events go out through a single
// output register; when the receiver stalls, the scan waits on the line whose
// event cannot be placed, and the input channel stays closed.
//
// Reset returns every line to on-hook, clears the relay and pending bits,
// stops all timers and sets the flash window to ten ticks.
module hook_flash_discriminator
  import hfd_pkg::*;
#(
  parameter int LINES = DEF_LINES
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] hook_bits, [10:8] line_index,
                                      // [18:11] release_ticks, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // event items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] event_line, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast,   // last_event
  // flash window register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state;
  logic [LW-1:0]      cnt;
  logic [7:0]         window;
  logic [LINES-1:0]   stored_hook;
  logic [LINES-1:0]   relay_mask;
  logic [LINES-1:0]   release_pending;
  logic [7:0]         line_timer [LINES];

  // Latched description of the pass in progress.
  logic               scan_tick;
  logic [LINES-1:0]   scan_changed;
  logic [LINES-1:0]   scan_level;
  logic [LINES-1:0]   ev_mask;      // lines that still owe an event

  logic               out_valid;
  logic [2:0]         out_line;
  logic [1:0]         out_kind;
  logic               out_last;

  logic [1:0]         cmd;
  logic [7:0]         hook_in;
  logic [2:0]         idx_in;
  logic [7:0]         rel_in;
  logic [LINES-1:0]   sample;
  logic [LINES-1:0]   changed;
  logic [LINES-1:0]   tick_ev;
  logic               idx_ok;
  logic               accept;
  logic               out_free;
  logic               step;
  logic [LINES-1:0]   cur_bit;

  line_req_t          req;
  line_res_t          res;

  assign cmd     = s_axis_tuser;
  assign hook_in = s_axis_tdata[7:0];
  assign idx_in  = s_axis_tdata[10:8];
  assign rel_in  = s_axis_tdata[18:11];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign sample  = hook_in[LINES-1:0];
  assign changed = (sample ^ stored_hook) & ~relay_mask;
  assign idx_ok  = (32'(idx_in) < LINES);

  // Lines whose timer expires on this tick without a pending release.
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      tick_ev[i] = (line_timer[i] == 8'd1) && !release_pending[i];
    end
  end

  // Shared line unit, fed with the line under scan.
  assign req.is_tick = scan_tick;
  assign req.changed = scan_changed[cnt];
  assign req.level   = scan_level[cnt];
  assign req.pending = release_pending[cnt];
  assign req.timer   = line_timer[cnt];
  assign req.window  = window;

  hfd_line_unit u_line (
    .req (req),
    .res (res)
  );

  assign cur_bit  = LINES'(1) << cnt;
  assign out_free = !out_valid || m_axis_tready;
  // The scan moves on unless this line has an event with nowhere to go.
  assign step     = (state == ST_SCAN) && (!res.emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= FLASH_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      stored_hook     <= '1;
      relay_mask      <= '0;
      release_pending <= '0;
      ev_mask         <= '0;
      scan_tick       <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        line_timer[i] <= 8'd0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_SAMPLE: begin
                if (changed != '0) begin
                  stored_hook  <= sample;
                  scan_tick    <= 1'b0;
                  scan_changed <= changed;
                  scan_level   <= sample;
                  ev_mask      <= changed & ~sample;
                  cnt          <= '0;
                  state        <= ST_SCAN;
                end
              end
              CMD_TICK: begin
                scan_tick <= 1'b1;
                ev_mask   <= tick_ev;
                cnt       <= '0;
                state     <= ST_SCAN;
              end
              CMD_ENGAGE: begin
                if (idx_ok) begin
                  relay_mask[idx_in[LW-1:0]] <= 1'b1;
                end
              end
              default: begin
                if (idx_ok) begin
                  if (rel_in == 8'd0) begin
                    relay_mask[idx_in[LW-1:0]]      <= 1'b0;
                    release_pending[idx_in[LW-1:0]] <= 1'b0;
                    line_timer[idx_in[LW-1:0]]      <= 8'd0;
                  end else begin
                    release_pending[idx_in[LW-1:0]] <= 1'b1;
                    line_timer[idx_in[LW-1:0]]      <= rel_in;
                  end
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (step) begin
            line_timer[cnt] <= res.timer_next;
            if (res.relay_off) begin
              relay_mask[cnt]      <= 1'b0;
              release_pending[cnt] <= 1'b0;
            end
            if (res.emit) begin
              ev_mask <= ev_mask & ~cur_bit;
            end
            if (32'(cnt) == LINES - 1) begin
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + LW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the scan places an event, emptied when the
  // receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_line <= 3'(cnt);
      out_kind <= res.kind;
      out_last <= ((ev_mask & ~cur_bit) == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_line};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule
